// File: rtl/mctl_pkg.sv
// ----------------------------------------------------------------------------
// mctl_pkg
// shared types and constants of the moesi tag, state and lru controller
// ----------------------------------------------------------------------------
package mctl_pkg;

  localparam int unsigned ModeW  = 3;
  localparam int unsigned StW    = 3;
  localparam int unsigned BusW   = 2;

  // cache geometry, fixed to match the channel field widths
  localparam int unsigned Ways      = 8;
  localparam int unsigned Sets      = 128;
  localparam int unsigned LineBytes = 32;
  localparam int unsigned TagBits   = 20;
  localparam int unsigned OffW      = $clog2(LineBytes);
  localparam int unsigned SetW      = $clog2(Sets);
  localparam int unsigned WayW      = $clog2(Ways);
  localparam int unsigned AgeW      = $clog2(Ways + 1);

  localparam logic [ModeW-1:0] ModeCpuRd   = 3'd0;
  localparam logic [ModeW-1:0] ModeCpuWr   = 3'd1;
  localparam logic [ModeW-1:0] ModeSnpRd   = 3'd2;
  localparam logic [ModeW-1:0] ModeSnpUpg  = 3'd3;
  localparam logic [ModeW-1:0] ModeSnpRdx  = 3'd4;

  localparam logic [StW-1:0] StI = 3'd0;
  localparam logic [StW-1:0] StE = 3'd1;
  localparam logic [StW-1:0] StM = 3'd2;
  localparam logic [StW-1:0] StO = 3'd3;
  localparam logic [StW-1:0] StS = 3'd4;

  localparam logic [BusW-1:0] BusNone = 2'd0;
  localparam logic [BusW-1:0] BusRd   = 2'd1;
  localparam logic [BusW-1:0] BusUpg  = 2'd2;
  localparam logic [BusW-1:0] BusRdx  = 2'd3;

  typedef struct packed {
    logic rd;     // launch row read
    logic upd;    // write back the row and load the result register
  } cmd_t;

endpackage

// File: rtl/mctl_if.sv
// ----------------------------------------------------------------------------
// mctl_req_if / mctl_rsp_if / mctl_cfg_if
// valid-ready channels of the controller
// ----------------------------------------------------------------------------
interface mctl_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [31:0] address;
  logic [3:0] requester_id;
  logic       shared_response;
  modport source (output valid, mode, address, requester_id, shared_response, input ready);
  modport sink (input valid, mode, address, requester_id, shared_response, output ready);
endinterface

interface mctl_rsp_if;
  logic       valid;
  logic       ready;
  logic       hit;
  logic [6:0] set_index;
  logic [2:0] way_index;
  logic [1:0] bus_request;
  logic       flush;
  logic [2:0] old_state;
  logic [2:0] new_state;
  modport source (output valid, hit, set_index, way_index, bus_request, flush, old_state,
                  new_state, input ready);
  modport sink (input valid, hit, set_index, way_index, bus_request, flush, old_state,
                new_state, output ready);
endinterface

interface mctl_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// File: rtl/mctl_ctrl.sv
// ----------------------------------------------------------------------------
// mctl_ctrl
// sequencer: accept, read set row, update row and present result
// ----------------------------------------------------------------------------
module mctl_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output mctl_pkg::cmd_t   cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LOOK = 3'b010,
    S_OUT  = 3'b100
  } state_e;

  state_e state_q, state_d;

  // a new item may enter while the previous result is taken
  assign in_ready_o  = (state_q == S_IDLE) || (state_q == S_OUT && out_ready_i);
  assign out_valid_o = (state_q == S_OUT);
  assign cmd_o.rd    = in_valid_i && in_ready_o;
  assign cmd_o.upd   = (state_q == S_LOOK);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_LOOK;
      S_LOOK: state_d = S_OUT;
      S_OUT: begin
        if (out_ready_i) state_d = in_valid_i ? S_LOOK : S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

`ifndef SYNTHESIS
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_look_then_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LOOK |=> state_q == S_OUT) else $error("lookup not followed by result");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");
`endif

endmodule

// File: rtl/mctl_dp.sv
// ----------------------------------------------------------------------------
// mctl_dp
// set-row memories, hit detect, victim pick, moesi next state and lru ages
// ----------------------------------------------------------------------------
module mctl_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mctl_pkg::cmd_t       cmd_i,
  input  logic [3:0]           own_id_i,
  input  logic [2:0]           mode_i,
  input  logic [31:0]          address_i,
  input  logic [3:0]           requester_id_i,
  input  logic                 shared_response_i,
  output logic                 hit_o,
  output logic [6:0]           set_index_o,
  output logic [2:0]           way_index_o,
  output logic [1:0]           bus_request_o,
  output logic                 flush_o,
  output logic [2:0]           old_state_o,
  output logic [2:0]           new_state_o
);

  localparam int unsigned WAYS     = mctl_pkg::Ways;
  localparam int unsigned SETS     = mctl_pkg::Sets;
  localparam int unsigned TAG_BITS = mctl_pkg::TagBits;
  localparam int unsigned OffW     = mctl_pkg::OffW;
  localparam int unsigned SetW     = mctl_pkg::SetW;
  localparam int unsigned WayW     = mctl_pkg::WayW;
  localparam int unsigned AgeW     = mctl_pkg::AgeW;
  localparam int unsigned StW      = mctl_pkg::StW;

  typedef logic [TAG_BITS-1:0]  tag_t;
  typedef logic [WAYS-1:0][TAG_BITS-1:0] tag_row_t;
  typedef logic [WAYS-1:0][StW-1:0]      st_row_t;
  typedef logic [WAYS-1:0][AgeW-1:0]     age_row_t;

  // per-set row memories; state and age rows carry a valid bit per set
  tag_row_t tag_mem [SETS];
  st_row_t  st_mem  [SETS];
  age_row_t age_mem [SETS];
  logic [SETS-1:0] row_vld_q;

  tag_row_t tag_rd_q;
  st_row_t  st_rd_q;
  age_row_t age_rd_q;
  logic     vld_rd_q;

  logic [2:0]      mode_q;
  logic [SetW-1:0] set_q;
  tag_t            tag_q;
  logic            shr_q, own_q;

  logic [SetW-1:0] set_in;
  logic [31-OffW:0] blk;
  tag_t            tag_in;

  assign blk    = address_i[31:OffW];
  assign set_in = blk[SetW-1:0];
  assign tag_in = blk[SetW +: TAG_BITS];

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      tag_rd_q <= tag_mem[set_in];
      st_rd_q  <= st_mem[set_in];
      age_rd_q <= age_mem[set_in];
      mode_q   <= mode_i;
      set_q    <= set_in;
      tag_q    <= tag_in;
      shr_q    <= shared_response_i;
      own_q    <= (requester_id_i == own_id_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_rd_q <= 1'b0;
    else if (cmd_i.rd) vld_rd_q <= row_vld_q[set_in];
  end

  st_row_t  st_cur;
  age_row_t age_cur;
  assign st_cur  = vld_rd_q ? st_rd_q : '0;
  assign age_cur = vld_rd_q ? age_rd_q : '0;

  logic hit;
  logic [WayW-1:0] hway, vway, way;
  logic found_zero;
  logic [AgeW-1:0] top;

  always_comb begin
    hit = 1'b0;
    hway = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (st_cur[w] != mctl_pkg::StI && tag_rd_q[w] == tag_q) begin
        hit = 1'b1;
        hway = WayW'(w);
      end
    end
  end

  always_comb begin
    found_zero = 1'b0;
    vway = '0;
    top = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (age_cur[w] > top) begin
        top = age_cur[w];
        vway = WayW'(w);
      end
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (age_cur[w] == '0) begin
        found_zero = 1'b1;
        vway = WayW'(w);
      end
    end
  end

  logic cpu, snp, wr_st, do_touch, res_hit, fl;
  logic [1:0] bus;
  logic [StW-1:0] olds, news;
  tag_row_t tag_new;
  st_row_t  st_new;
  age_row_t age_new;
  logic [AgeW-1:0] prev;

  assign cpu = (mode_q == mctl_pkg::ModeCpuRd) || (mode_q == mctl_pkg::ModeCpuWr);
  assign snp = ((mode_q == mctl_pkg::ModeSnpRd) || (mode_q == mctl_pkg::ModeSnpUpg) ||
                (mode_q == mctl_pkg::ModeSnpRdx)) && !own_q;

  always_comb begin
    res_hit = 1'b0;
    way = '0;
    bus = mctl_pkg::BusNone;
    fl = 1'b0;
    olds = mctl_pkg::StI;
    news = mctl_pkg::StI;
    wr_st = 1'b0;
    do_touch = 1'b0;
    tag_new = tag_rd_q;
    if (cpu) begin
      res_hit = hit;
      wr_st = 1'b1;
      do_touch = 1'b1;
      if (hit) begin
        way = hway;
        olds = st_cur[hway];
        news = olds;
        if (mode_q == mctl_pkg::ModeCpuWr) begin
          if (olds == mctl_pkg::StS || olds == mctl_pkg::StO) bus = mctl_pkg::BusUpg;
          news = mctl_pkg::StM;
        end
      end else begin
        way = vway;
        if (mode_q == mctl_pkg::ModeCpuWr) begin
          bus = mctl_pkg::BusRdx;
          news = mctl_pkg::StM;
        end else begin
          bus = mctl_pkg::BusRd;
          news = shr_q ? mctl_pkg::StS : mctl_pkg::StE;
        end
        tag_new[vway] = tag_q;
      end
    end else if (snp && hit) begin
      res_hit = 1'b1;
      way = hway;
      wr_st = 1'b1;
      olds = st_cur[hway];
      news = olds;
      case (mode_q)
        mctl_pkg::ModeSnpRd: begin
          if (olds != mctl_pkg::StS) begin
            news = mctl_pkg::StO;
            fl = 1'b1;
          end
        end
        mctl_pkg::ModeSnpUpg: begin
          if (olds == mctl_pkg::StS || olds == mctl_pkg::StO) news = mctl_pkg::StI;
        end
        default: begin
          fl = (olds != mctl_pkg::StS);
          news = mctl_pkg::StI;
        end
      endcase
    end
  end

  // line hit / victim gets age one, younger used lines grow older
  always_comb begin
    st_new = st_cur;
    if (wr_st) st_new[way] = news;
    prev = age_cur[way];
    age_new = age_cur;
    if (do_touch && prev != AgeW'(1)) begin
      for (int w = 0; w < WAYS; w++) begin
        if (WayW'(w) == way) age_new[w] = AgeW'(1);
        else if (age_cur[w] != '0 && (prev == '0 || age_cur[w] < prev))
          age_new[w] = age_cur[w] + AgeW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd) begin
      tag_mem[set_q] <= tag_new;
      st_mem[set_q]  <= st_new;
      age_mem[set_q] <= age_new;
      hit_o         <= res_hit;
      set_index_o   <= 7'(set_q);
      way_index_o   <= 3'(way);
      bus_request_o <= bus;
      flush_o       <= fl;
      old_state_o   <= olds;
      new_state_o   <= news;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) row_vld_q <= '0;
    else if (cmd_i.upd) row_vld_q[set_q] <= 1'b1;
  end

`ifndef SYNTHESIS
  a_flush_snoop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.upd && fl |-> snp && res_hit) else $error("flush outside a snoop hit");
  a_bus_cpu: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.upd && bus != mctl_pkg::BusNone |-> cpu) else $error("bus request on snoop");
  a_miss_victim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.upd && cpu && !hit && found_zero |-> age_cur[vway] == '0)
    else $error("victim not unused");
`endif

endmodule

// File: rtl/moesi_cache_tag_controller_lru_core.sv
// ----------------------------------------------------------------------------
// moesi_cache_tag_controller_lru_core
// tag, moesi state and lru controller of a set-associative snooping cache
// ----------------------------------------------------------------------------
// channels: req (mode, address, requester_id, shared_response) in, rsp out,
// cfg carries own_id; snoops from own_id leave every line alone.
// every beat on req gives exactly one beat on rsp.
// an accepted item passes the lookup state, where its set row is written back
// and the result registered; the next item waits for the read then write of
// one set row in the row memories and enters as the result is taken.
// a stalled rsp holds its beat and req stays not ready until it is taken.
// reset empties every set through one valid flop per set, all lines invalid
// and all ages unused; own_id returns to 0. no clearing pass is needed.
// cfg is always ready and must only be written while the block is idle.
// ----------------------------------------------------------------------------
module moesi_cache_tag_controller_lru_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  mctl_req_if.sink    req,
  mctl_rsp_if.source  rsp,
  mctl_cfg_if.sink    cfg
);

  logic [3:0]     own_id_q;
  mctl_pkg::cmd_t cmd;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) own_id_q <= '0;
    else if (cfg.valid) own_id_q <= cfg.data;
  end

  mctl_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(req.valid), .in_ready_o(req.ready),
    .out_valid_o(rsp.valid), .out_ready_i(rsp.ready),
    .cmd_o(cmd)
  );

  mctl_dp u_dp (
    .clk_i, .rst_ni,
    .cmd_i(cmd), .own_id_i(own_id_q),
    .mode_i(req.mode), .address_i(req.address), .requester_id_i(req.requester_id),
    .shared_response_i(req.shared_response),
    .hit_o(rsp.hit), .set_index_o(rsp.set_index), .way_index_o(rsp.way_index),
    .bus_request_o(rsp.bus_request), .flush_o(rsp.flush),
    .old_state_o(rsp.old_state), .new_state_o(rsp.new_state)
  );

endmodule
